### hdl/ipv6_text_address_parser_unit_defines.svh
// Assertion macros for the IPv6 text address parser unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef IPV6_TEXT_ADDRESS_PARSER_UNIT_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on the rising clock edge, off while reset is held.
`define IPV6TAP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define IPV6TAP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IPV6TAP_ASSERT(name, clk, rst_n, prop, msg)
`define IPV6TAP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### hdl/ipv6tap_pkg.sv
// Shared types and constants of the IPv6 text address parser unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ipv6tap_pkg;

    localparam int GROUPS = 8;

    localparam logic [3:0]  NO_GAP     = 4'd15;
    localparam logic [3:0]  GROUPS_ALL = 4'd8;
    localparam logic [15:0] BCD_MAX    = 16'h0255;
    localparam logic [11:0] OCTET_MAX  = 12'd255;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEAD,
        PH_TOP,
        PH_HEX,
        PH_V4_START,
        PH_V4_DIGITS
    } t_phase;

    typedef logic [15:0] t_group;
    typedef logic [GROUPS-1:0][15:0] t_group_vec;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  group_index;
        logic [3:0]  gap_position;
        logic [15:0] hex_value;
        logic [2:0]  digit_count;
        logic [1:0]  octet_index;
        logic [7:0]  octet_value;
        logic        failed;
    } t_state;

    // One group write per item: byte enables, group slot and data.
    typedef struct packed {
        logic        we_hi;
        logic        we_lo;
        logic [2:0]  idx;
        logic [15:0] data;
    } t_grp_wr;

    localparam t_state STATE_RESET = '{
        phase:        PH_START,
        group_index:  4'd0,
        gap_position: NO_GAP,
        hex_value:    16'd0,
        digit_count:  3'd0,
        octet_index:  2'd0,
        octet_value:  8'd0,
        failed:       1'b0
    };

endpackage

### hdl/ipv6tap_step.sv
// Next-state logic for one character: parse step plus end-of-text fixup.
// Depends on ipv6tap_pkg.
`timescale 1ns / 1ps

module ipv6tap_step (
    input  ipv6tap_pkg::t_state  i_state,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    output ipv6tap_pkg::t_state  o_state,
    output ipv6tap_pkg::t_grp_wr o_wr
);

    logic                is_dec;
    logic                is_lo;
    logic                is_up;
    logic                is_hex;
    logic [3:0]          dig;
    logic                colon;
    logic                dot;

    always_comb begin
        is_dec = (i_ch >= ipv6tap_pkg::CH_0)  && (i_ch <= ipv6tap_pkg::CH_9);
        is_lo  = (i_ch >= ipv6tap_pkg::CH_LA) && (i_ch <= ipv6tap_pkg::CH_LF);
        is_up  = (i_ch >= ipv6tap_pkg::CH_UA) && (i_ch <= ipv6tap_pkg::CH_UF);
        is_hex = is_dec || is_lo || is_up;
        dig    = is_dec ? i_ch[3:0] : (i_ch[3:0] + 4'd9);
        colon  = (i_ch == ipv6tap_pkg::CH_COLON);
        dot    = (i_ch == ipv6tap_pkg::CH_DOT);
    end

    always_comb begin
        ipv6tap_pkg::t_state  s;
        ipv6tap_pkg::t_grp_wr wr;
        ipv6tap_pkg::t_phase  ph;
        logic                 go;
        logic [9:0]           conv;
        logic [11:0]          dec_next;
        logic [3:0]           gsum;

        s        = i_state;
        wr       = '0;
        ph       = i_state.phase;
        go       = !i_state.failed;
        conv     = 10'(i_state.hex_value[9:8]) * 10'd100
                 + 10'(i_state.hex_value[7:4]) * 10'd10
                 + 10'(i_state.hex_value[3:0]);
        dec_next = 12'(i_state.octet_value) * 12'd10 + 12'(dig);
        gsum     = i_state.group_index + {3'b000, i_state.octet_index[1]};

        if (go && ph == ipv6tap_pkg::PH_START) begin
            if (colon) begin
                if (i_last) begin
                    s.failed = 1'b1;
                end else begin
                    s.phase = ipv6tap_pkg::PH_LEAD;
                end
                go = 1'b0;
            end else begin
                ph      = ipv6tap_pkg::PH_TOP;
                s.phase = ipv6tap_pkg::PH_TOP;
            end
        end

        if (go) begin
            case (ph)
                ipv6tap_pkg::PH_LEAD: begin
                    if (!colon) begin
                        s.failed = 1'b1;
                    end else begin
                        wr.we_hi       = 1'b1;
                        wr.we_lo       = 1'b1;
                        wr.idx         = 3'd0;
                        s.group_index  = 4'd1;
                        s.gap_position = 4'd1;
                        s.phase        = ipv6tap_pkg::PH_TOP;
                    end
                end
                ipv6tap_pkg::PH_TOP: begin
                    if (i_state.group_index >= ipv6tap_pkg::GROUPS_ALL) begin
                        s.failed = 1'b1;
                    end else if (colon) begin
                        if (i_state.gap_position != ipv6tap_pkg::NO_GAP) begin
                            s.failed = 1'b1;
                        end else begin
                            wr.we_hi       = 1'b1;
                            wr.we_lo       = 1'b1;
                            wr.idx         = i_state.group_index[2:0];
                            s.group_index  = i_state.group_index + 4'd1;
                            s.gap_position = i_state.group_index + 4'd1;
                        end
                    end else if (!is_hex) begin
                        s.failed = 1'b1;
                    end else begin
                        s.hex_value   = 16'(dig);
                        s.digit_count = 3'd1;
                        s.phase       = ipv6tap_pkg::PH_HEX;
                    end
                end
                ipv6tap_pkg::PH_HEX: begin
                    if (is_hex) begin
                        if (i_state.digit_count >= 3'd4) begin
                            s.failed = 1'b1;
                        end else begin
                            s.hex_value   = {i_state.hex_value[11:0], dig};
                            s.digit_count = i_state.digit_count + 3'd1;
                        end
                    end else if (colon) begin
                        if (i_last) begin
                            s.failed = 1'b1;
                        end else begin
                            wr.we_hi      = 1'b1;
                            wr.we_lo      = 1'b1;
                            wr.idx        = i_state.group_index[2:0];
                            wr.data       = i_state.hex_value;
                            s.group_index = i_state.group_index + 4'd1;
                            s.phase       = ipv6tap_pkg::PH_TOP;
                        end
                    end else if (dot) begin
                        // First dotted octet was read as hex; accept BCD up to 255.
                        if (i_state.group_index > 4'd6
                                || i_state.hex_value > ipv6tap_pkg::BCD_MAX
                                || i_state.hex_value[7:4] > 4'd9
                                || i_state.hex_value[3:0] > 4'd9) begin
                            s.failed = 1'b1;
                        end else begin
                            wr.we_hi      = 1'b1;
                            wr.we_lo      = 1'b1;
                            wr.idx        = i_state.group_index[2:0];
                            wr.data       = {conv[7:0], 8'h00};
                            s.octet_index = 2'd1;
                            s.phase       = ipv6tap_pkg::PH_V4_START;
                        end
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                ipv6tap_pkg::PH_V4_START: begin
                    if (!is_dec) begin
                        s.failed = 1'b1;
                    end else begin
                        s.octet_value = 8'(dig);
                        s.phase       = ipv6tap_pkg::PH_V4_DIGITS;
                    end
                end
                ipv6tap_pkg::PH_V4_DIGITS: begin
                    if (is_dec) begin
                        if (dec_next > ipv6tap_pkg::OCTET_MAX) begin
                            s.failed = 1'b1;
                        end else begin
                            s.octet_value = dec_next[7:0];
                        end
                    end else if (dot && i_state.octet_index < 2'd3) begin
                        wr.idx = gsum[2:0];
                        if (i_state.octet_index[0]) begin
                            wr.we_lo = 1'b1;
                            wr.data  = {8'h00, i_state.octet_value};
                        end else begin
                            wr.we_hi = 1'b1;
                            wr.we_lo = 1'b1;
                            wr.data  = {i_state.octet_value, 8'h00};
                        end
                        s.octet_index = i_state.octet_index + 2'd1;
                        s.phase       = ipv6tap_pkg::PH_V4_START;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                default: begin
                    s.failed = 1'b1;
                end
            endcase
        end

        // End of text: flush the open group or last octet, and fail an incomplete address.
        if (i_last && !s.failed) begin
            case (s.phase)
                ipv6tap_pkg::PH_HEX: begin
                    wr.we_hi      = 1'b1;
                    wr.we_lo      = 1'b1;
                    wr.idx        = s.group_index[2:0];
                    wr.data       = s.hex_value;
                    s.group_index = s.group_index + 4'd1;
                end
                ipv6tap_pkg::PH_V4_DIGITS: begin
                    if (s.octet_index == 2'd3) begin
                        wr.we_hi      = 1'b0;
                        wr.we_lo      = 1'b1;
                        wr.idx        = 3'(s.group_index + 4'd1);
                        wr.data       = {8'h00, s.octet_value};
                        s.group_index = s.group_index + 4'd2;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                ipv6tap_pkg::PH_TOP: begin
                    s.failed = s.failed;
                end
                default: begin
                    s.failed = 1'b1;
                end
            endcase
            if (s.gap_position == ipv6tap_pkg::NO_GAP
                    && s.group_index != ipv6tap_pkg::GROUPS_ALL) begin
                s.failed = 1'b1;
            end
        end

        o_state = s;
        o_wr    = wr;
    end

endmodule

### hdl/ipv6tap_stretch.sv
// Result mux: stretches the double-colon gap with zero groups and packs the address.
// Depends on ipv6tap_pkg.
`timescale 1ns / 1ps

module ipv6tap_stretch (
    input  ipv6tap_pkg::t_group_vec i_groups,
    input  logic [3:0]              i_group_index,
    input  logic [3:0]              i_gap_position,
    input  logic                    i_failed,
    output logic [63:0]             o_addr_high,
    output logic [63:0]             o_addr_low,
    output logic                    o_valid
);

    ipv6tap_pkg::t_group_vec lanes;
    logic [3:0]              gap;
    logic [3:0]              ncopy;

    always_comb begin
        gap   = (i_gap_position == ipv6tap_pkg::NO_GAP) ? ipv6tap_pkg::GROUPS_ALL
                                                        : i_gap_position;
        ncopy = (i_group_index >= gap) ? (i_group_index - gap) : 4'd0;
    end

    // Each output group picks its source on its own: head, moved tail, or zero.
    always_comb begin
        logic [4:0] lsum;
        lsum = '0;
        for (int t = 0; t < ipv6tap_pkg::GROUPS; t++) begin
            lsum = 5'(gap) + 5'(t) + 5'(ncopy);
            if (i_failed) begin
                lanes[t] = '0;
            end else if (4'(t) < gap) begin
                lanes[t] = i_groups[t];
            end else if (lsum - 5'(gap) >= 5'(ipv6tap_pkg::GROUPS)) begin
                lanes[t] = i_groups[lsum[2:0]];
            end else begin
                lanes[t] = '0;
            end
        end
    end

    assign o_addr_high = {lanes[0], lanes[1], lanes[2], lanes[3]};
    assign o_addr_low  = {lanes[4], lanes[5], lanes[6], lanes[7]};
    assign o_valid     = !i_failed;

endmodule

### hdl/ipv6_text_address_parser_unit.sv
// Top level of the IPv6 text address parser: parse state, group registers, output buffer.
// Depends on ipv6tap_pkg, ipv6tap_step, ipv6tap_stretch and the defines header.
`timescale 1ns / 1ps
`include "ipv6_text_address_parser_unit_defines.svh"

// Usage
//   Slave stream: one ASCII character of an IPv6 address text per item in
//   tdata, tlast high on the final character. Strings with embedded IPv4
//   dotted tails and a single "::" are accepted.
//   Master stream: one item per string, sent for the tlast character.
//   tdata carries the 128-bit address, addr_high in the low half and addr_low
//   in the high half, group 0 in the top bits of addr_high; tuser is high
//   when the text was well formed; malformed text yields all zeros.
// Throughput and result path
//   One character per cycle while the skid is empty. The result item is
//   registered in the output register, or in the skid if that is held. The
//   path is one pass of character decode and state update, then the
//   gap-stretch mux, between the parse registers and the output register.
// Reset and stall
//   Synchronous active-low reset clears the parse state and empties the
//   output buffer; the group registers need no clearing, since only groups
//   written by the current string are read. A two-entry output buffer
//   (output register plus skid) keeps input flowing while a result waits;
//   tready drops only once both entries hold results.

module ipv6_text_address_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Slave side
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] ch
    input  logic         i_s_axis_tlast,   // last
    // Master side
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic [0:0]   o_m_axis_tuser    // [0] valid_res
);

    ipv6tap_pkg::t_state     r_state;
    ipv6tap_pkg::t_state     n_state;
    ipv6tap_pkg::t_state     step_state;
    ipv6tap_pkg::t_grp_wr    step_wr;
    ipv6tap_pkg::t_group_vec r_groups;
    ipv6tap_pkg::t_group_vec n_groups;

    logic [63:0]  res_high;
    logic [63:0]  res_low;
    logic         res_valid;

    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic         r_out_user;
    logic         r_skid_valid;
    logic [127:0] r_skid_data;
    logic         r_skid_user;

    logic         in_accept;
    logic         new_res;
    logic         out_free;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign new_res         = in_accept && i_s_axis_tlast;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    ipv6tap_step u_step (
        .i_state (r_state),
        .i_ch    (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_state (step_state),
        .o_wr    (step_wr)
    );

    // Apply this item's group write ahead of the stretch so the final group is seen.
    always_comb begin
        n_groups = r_groups;
        if (step_wr.we_hi) begin
            n_groups[step_wr.idx][15:8] = step_wr.data[15:8];
        end
        if (step_wr.we_lo) begin
            n_groups[step_wr.idx][7:0] = step_wr.data[7:0];
        end
    end

    ipv6tap_stretch u_stretch (
        .i_groups       (n_groups),
        .i_group_index  (step_state.group_index),
        .i_gap_position (step_state.gap_position),
        .i_failed       (step_state.failed),
        .o_addr_high    (res_high),
        .o_addr_low     (res_low),
        .o_valid        (res_valid)
    );

    // Back to the start-of-string state once a string ends.
    always_comb begin
        n_state = r_state;
        if (in_accept) begin
            n_state = i_s_axis_tlast ? ipv6tap_pkg::STATE_RESET : step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv6tap_pkg::STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_groups <= n_groups;
        end
    end

    // Output buffer: advance the skid into the output register when it frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= new_res;
            end
        end else if (new_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else if (new_res) begin
                r_out_data <= {res_low, res_high};
                r_out_user <= res_valid;
            end
        end else if (new_res) begin
            r_skid_data <= {res_low, res_high};
            r_skid_user <= res_valid;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;

    `IPV6TAP_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid holds an item while the output register is empty")
    `IPV6TAP_ASSERT(a_result_follows_last, i_clk, i_rst_n, new_res |=> o_m_axis_tvalid, "no result item after a final character")
    `IPV6TAP_ASSERT(a_state_cleared, i_clk, i_rst_n, new_res |=> (r_state.phase == ipv6tap_pkg::PH_START && r_state.group_index == 4'd0 && !r_state.failed), "parse state not cleared after a string")
    `IPV6TAP_ASSERT(a_bad_text_zero, i_clk, i_rst_n, (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 128'd0), "malformed text gave a nonzero address")

endmodule

### tb/tb_ipv6_text_address_parser_unit.sv
// Self-checking testbench of the IPv6 text address parser unit: feeds address texts one
// character per item and checks every address item against an in-bench parse of the text.
// Depends on ipv6tap_pkg and the ipv6_text_address_parser_unit RTL.
`timescale 1ns / 1ps

module tb_ipv6_text_address_parser_unit;

    import ipv6tap_pkg::*;

    localparam int IDLE_PCT     = 6;       // chance of a gap or stall, in percent
    localparam int QUIET_FROM   = 700;     // cycle window with no gaps and no stalls
    localparam int QUIET_TO     = 1200;
    localparam int RANDOM_CHARS = 1250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [4:0] NOT_HEX = 5'd16;

    typedef logic [7:0] t_text[$];

    // One queued character; a hold entry sends nothing and waits for all addresses.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       hold;
    } t_char_item;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        well_formed;
    } t_address;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    int cycle_count = 0;
    int errors = 0;
    logic quiet;

    t_char_item text_chars[$];
    t_address   addr_expected[$];

    // In-bench parse state of the text in flight.
    t_phase      ph;
    logic [3:0]  gidx;
    logic [3:0]  gap_at;
    logic [15:0] acc;
    logic [2:0]  ndig;
    logic [1:0]  oct_idx;
    logic [8:0]  oct_val;
    logic        bad;
    logic [15:0] groups [8];

    ipv6_text_address_parser_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] ch
        .i_s_axis_tlast  (s_tlast),    // last
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [63:0] addr_high, [127:64] addr_low
        .o_m_axis_tuser  (m_tuser)     // [0] valid_res
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    // ---------------------------------------------------------------- parse model

    function automatic void clear_parse();
        ph      = PH_START;
        gidx    = '0;
        gap_at  = NO_GAP;
        acc     = '0;
        ndig    = '0;
        oct_idx = '0;
        oct_val = '0;
        bad     = 1'b0;
        for (int i = 0; i < 8; i++) groups[i] = '0;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
        return NOT_HEX;
    endfunction

    // Octets 0/1 fill the current group, 2/3 the next; an even octet clears the low byte.
    function automatic void store_octet(input logic [1:0] k, input logic [7:0] v);
        logic [2:0] g;
        g = 3'(gidx + {3'b000, k[1]});
        if (k[0]) groups[g][7:0] = v;
        else groups[g] = {v, 8'h00};
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic fin);
        logic [4:0] d;
        int         dec;
        d = hex_digit(c);
        // A leading colon must be followed by a second one.
        if (ph == PH_START) begin
            if (c == CH_COLON) begin
                if (fin) bad = 1'b1;
                else ph = PH_LEAD;
                return;
            end
            ph = PH_TOP;
        end
        case (ph)
            PH_LEAD: begin
                if (c != CH_COLON) begin
                    bad = 1'b1;
                end else begin
                    groups[0] = '0;
                    gidx      = 4'd1;
                    gap_at    = 4'd1;
                    ph        = PH_TOP;
                end
            end
            PH_TOP: begin
                if (gidx >= GROUPS_ALL) begin
                    bad = 1'b1;
                end else if (c == CH_COLON) begin
                    if (gap_at != NO_GAP) begin
                        bad = 1'b1;
                    end else begin
                        groups[gidx[2:0]] = '0;
                        gidx   = gidx + 4'd1;
                        gap_at = gidx;
                    end
                end else if (d == NOT_HEX) begin
                    bad = 1'b1;
                end else begin
                    acc  = {12'h000, d[3:0]};
                    ndig = 3'd1;
                    ph   = PH_HEX;
                end
            end
            PH_HEX: begin
                if (d != NOT_HEX) begin
                    if (ndig >= 3'd4) begin
                        bad = 1'b1;
                    end else begin
                        acc  = {acc[11:0], d[3:0]};
                        ndig = ndig + 3'd1;
                    end
                end else if (c == CH_COLON) begin
                    if (fin) begin
                        bad = 1'b1;
                    end else begin
                        groups[gidx[2:0]] = acc;
                        gidx = gidx + 4'd1;
                        ph   = PH_TOP;
                    end
                end else if (c == CH_DOT) begin
                    // First dotted octet arrives as hex digits: accept BCD up to 255 only.
                    if (gidx > 4'd6 || acc > BCD_MAX || acc[7:4] > 4'd9 || acc[3:0] > 4'd9) begin
                        bad = 1'b1;
                    end else begin
                        dec = int'(acc[11:8]) * 100 + int'(acc[7:4]) * 10 + int'(acc[3:0]);
                        store_octet(2'd0, 8'(dec));
                        oct_idx = 2'd1;
                        ph      = PH_V4_START;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            PH_V4_START: begin
                if (d > 5'd9) begin
                    bad = 1'b1;
                end else begin
                    oct_val = 9'(d);
                    ph      = PH_V4_DIGITS;
                end
            end
            PH_V4_DIGITS: begin
                dec = int'(oct_val) * 10 + int'(d);
                if (d <= 5'd9) begin
                    if (dec > int'(OCTET_MAX)) bad = 1'b1;
                    else oct_val = 9'(dec);
                end else if (c == CH_DOT && oct_idx < 2'd3) begin
                    store_octet(oct_idx, oct_val[7:0]);
                    oct_idx = oct_idx + 2'd1;
                    ph      = PH_V4_START;
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase
    endfunction

    // Advance the parse by one accepted character; on the last one queue the address.
    function automatic void predict_char(input logic [7:0] c, input logic fin);
        int           span;
        int           ncopy;
        logic [127:0] word;
        logic [15:0]  g;
        if (!bad) parse_char(c, fin);
        if (fin) begin
            if (!bad) begin
                if (ph == PH_HEX) begin
                    groups[gidx[2:0]] = acc;
                    gidx = gidx + 4'd1;
                end else if (ph == PH_V4_DIGITS && oct_idx == 2'd3) begin
                    store_octet(2'd3, oct_val[7:0]);
                    gidx = gidx + 4'd2;
                end else if (ph != PH_TOP) begin
                    bad = 1'b1;
                end
            end
            if (!bad && gap_at == NO_GAP && gidx != GROUPS_ALL) bad = 1'b1;
            word = '0;
            if (!bad) begin
                // Move the groups after the gap to the tail and zero-fill the gap.
                span  = (gap_at == NO_GAP) ? 8 : int'(gap_at);
                ncopy = (int'(gidx) >= span) ? int'(gidx) - span : 0;
                for (int t = 0; t < 8; t++) begin
                    if (t < span) g = groups[t];
                    else if (t + ncopy >= 8) g = groups[(span + t + ncopy - 8) & 7];
                    else g = '0;
                    word[127 - 16 * t -: 16] = g;
                end
            end
            addr_expected.push_back('{word[127:64], word[63:0], !bad});
            clear_parse();
        end
    endfunction

    // ---------------------------------------------------------------- text builders

    function automatic t_text text_of(input string s);
        t_text q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + 8'(n);
        return (($urandom_range(1) == 0) ? CH_LA : CH_UA) + 8'(n - 4'd10);
    endfunction

    function automatic t_text hex_group_text();
        t_text q;
        int    n;
        n = $urandom_range(4, 1);
        // Pad to four digits now and then to exercise leading zeros.
        if ($urandom_range(4) == 0) for (int i = n; i < 4; i++) q.push_back(CH_0);
        for (int i = 0; i < n; i++) q.push_back(nibble_char(4'($urandom_range(15))));
        return q;
    endfunction

    function automatic t_text dec_text(input int v, input int pad);
        t_text q;
        for (int i = 0; i < pad; i++) q.push_back(CH_0);
        if (v >= 100) q.push_back(CH_0 + 8'(v / 100));
        if (v >= 10) q.push_back(CH_0 + 8'((v / 10) % 10));
        q.push_back(CH_0 + 8'(v % 10));
        return q;
    endfunction

    // Mostly in-range octets, a few just past 255.
    function automatic int octet_pick();
        if ($urandom_range(19) == 0) return $urandom_range(299, 256);
        return $urandom_range(255);
    endfunction

    function automatic t_text dotted_tail();
        t_text q;
        int    v;
        int    len;
        v   = octet_pick();
        len = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
        q   = dec_text(v, ($urandom_range(3) == 0) ? $urandom_range(4 - len) : 0);
        for (int k = 1; k < 4; k++) begin
            q.push_back(CH_DOT);
            q = {q, dec_text(octet_pick(), ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0)};
        end
        return q;
    endfunction

    function automatic t_text well_formed_text();
        t_text q;
        logic  v4;
        logic  gap;
        int    nhex;
        int    front;
        int    back;
        v4  = ($urandom_range(9) < 3);
        gap = ($urandom_range(9) < 6);
        if (gap) begin
            nhex  = $urandom_range(v4 ? 5 : 7);
            front = $urandom_range(nhex);
            back  = nhex - front;
        end else begin
            front = v4 ? 6 : 8;
            back  = 0;
        end
        for (int i = 0; i < front; i++) begin
            if (i > 0) q.push_back(CH_COLON);
            q = {q, hex_group_text()};
        end
        if (gap) begin
            q.push_back(CH_COLON);
            q.push_back(CH_COLON);
        end
        for (int i = 0; i < back; i++) begin
            if (i > 0) q.push_back(CH_COLON);
            q = {q, hex_group_text()};
        end
        if (v4) begin
            if ((!gap && front > 0) || (gap && back > 0)) q.push_back(CH_COLON);
            q = {q, dotted_tail()};
        end
        return q;
    endfunction

    // Characters near the grammar most of the time, any byte otherwise.
    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(9);
        if (r < 4) return nibble_char(4'($urandom_range(15)));
        if (r < 6) return CH_COLON;
        if (r < 7) return CH_DOT;
        return 8'($urandom_range(255));
    endfunction

    function automatic t_text broken_text(input t_text q);
        int pos;
        pos = $urandom_range(q.size() - 1);
        case ($urandom_range(4))
            0: q[pos] = random_char();
            1: if (q.size() > 1) q.delete(pos);
            2: q.insert(pos, random_char());
            3: while (q.size() > pos + 1) void'(q.pop_back());
            default: q.insert(pos, CH_COLON);
        endcase
        return q;
    endfunction

    function automatic t_text noise_text();
        t_text q;
        int    n;
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) q.push_back(random_char());
        return q;
    endfunction

    function automatic void queue_text(input t_text q);
        foreach (q[i]) text_chars.push_back('{q[i], i == q.size() - 1, 1'b0});
    endfunction

    function automatic void queue_hold();
        text_chars.push_back('{8'h00, 1'b0, 1'b1});
    endfunction

    // ---------------------------------------------------------------- stimulus

    initial begin
        string directed[$] = '{
            "::", "::1", "1::", "1:2:3:4:5:6:7:8",
            "0000:0000:0000:0000:0000:0000:0000:0000",
            "ffff:FFFF:aBcD:EF01:9:09:009:0009",
            "1:2:3:4::5:6:7", "1:2:3:4:5:6:7::",
            "::ffff:0255.255.000.09", "1:2:3:4:5:6:199.0.0.1",
            "::256.1.1.1", "::1.2.3.256", "::1a.2.3.4", "::1.2.3", "::1.2.3.4.5",
            "1:2:3:4:5:6:7:1.2.3.4", "1:2:3:4:5:6:7:8:9", "1::2::3",
            ":", ":1", "1:", "12345::", "::g"
        };
        t_text txt;
        int    rand_chars;
        int    pick;
        logic  mid_hold;

        clear_parse();
        foreach (directed[i]) queue_text(text_of(directed[i]));
        // A NUL inside the text is just a bad character, and so is a high byte.
        txt = text_of("1::");
        txt.push_back(8'h00);
        txt.push_back(CH_0 + 8'd1);
        queue_text(txt);
        txt = text_of("::");
        txt.push_back(8'hFF);
        queue_text(txt);
        queue_hold();

        rand_chars = 0;
        mid_hold   = 1'b0;
        while (rand_chars < RANDOM_CHARS) begin
            pick = $urandom_range(99);
            if (pick < 70) txt = well_formed_text();
            else if (pick < 90) txt = broken_text(well_formed_text());
            else txt = noise_text();
            queue_text(txt);
            rand_chars += txt.size();
            if (!mid_hold && rand_chars >= RANDOM_CHARS / 2) begin
                queue_hold();
                mid_hold = 1'b1;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last character and its address, then let the pipe drain.
        while (text_chars.size() != 0 || s_tvalid || addr_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (addr_expected.size() != 0) begin
            $display("%0t: %0d address items never arrived", $time, addr_expected.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    // Present the next character when the slot is free, with random gaps; a hold entry blocks until
    // every address has come back.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (text_chars.size() != 0 && text_chars[0].hold && addr_expected.size() == 0)
                    void'(text_chars.pop_front());
                if (text_chars.size() != 0 && !text_chars[0].hold &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_chars[0].ch;
                    s_tlast  <= text_chars[0].last;
                    void'(text_chars.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Compare each address item with the oldest prediction; stall at random.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (addr_expected.size() == 0) begin
                    $display("%0t: unexpected address item: expected none, actual %h / %b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    if (m_tdata[63:0] !== addr_expected[0].addr_high) begin
                        $display("%0t: addr_high mismatch: expected %h, actual %h",
                                 $time, addr_expected[0].addr_high, m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[127:64] !== addr_expected[0].addr_low) begin
                        $display("%0t: addr_low mismatch: expected %h, actual %h",
                                 $time, addr_expected[0].addr_low, m_tdata[127:64]);
                        errors++;
                    end
                    if (m_tuser[0] !== addr_expected[0].well_formed) begin
                        $display("%0t: valid_res mismatch: expected %b, actual %b",
                                 $time, addr_expected[0].well_formed, m_tuser[0]);
                        errors++;
                    end
                    void'(addr_expected.pop_front());
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

endmodule
